// ===== hdl/length_type_deframer_macros.svh =====
// Assertion macros shared by the deframer checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LENGTH_TYPE_DEFRAMER_MACROS_SVH
`define LENGTH_TYPE_DEFRAMER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LTD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// ===== hdl/ltd_pkg.sv =====
// Package for the length/type deframer: field widths, header constants and
// the result record. No dependencies.
`timescale 1ns / 1ps

package ltd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = 4;

  // Header byte counter: 0..7 while the header arrives, 8 while payload passes.
  localparam logic [CNT_W-1:0] HDR_LAST      = 4'd7;
  localparam logic [CNT_W-1:0] PAYLOAD_PHASE = 4'd8;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic [WORD_W-1:0] message_type;
    logic [WORD_W-1:0] message_length;
    logic              first_byte;
    logic              last_byte;
    logic              empty_message;
  } ltd_result_t;

endpackage

// ===== hdl/ltd_ifs.sv =====
// Valid/ready channel interfaces for the deframer's byte input and result output.
// Depends on ltd_pkg for field widths.
`timescale 1ns / 1ps

interface ltd_in_if
  import ltd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface ltd_out_if
  import ltd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic [WORD_W-1:0] message_type;
  logic [WORD_W-1:0] message_length;
  logic              first_byte;
  logic              last_byte;
  logic              empty_message;

  modport source (output valid, output payload_byte, output message_type,
                  output message_length, output first_byte, output last_byte,
                  output empty_message, input ready);
  modport sink   (input valid, input payload_byte, input message_type,
                  input message_length, input first_byte, input last_byte,
                  input empty_message, output ready);
endinterface

// ===== hdl/length_type_deframer.sv =====
// Length/type deframer top level: splits a byte stream into header and payload.
// Depends on ltd_pkg and the channel interfaces in ltd_ifs.sv.
`timescale 1ns / 1ps
//
//  Channel   Direction  Carries
//  in_ch     sink       one raw stream byte per transfer
//  out_ch    source     one tagged payload byte, or one empty-message marker
//
//  One byte is taken per clock while in_ch.ready is high; its result, if any,
//  is shown the next cycle from the output register. Header bytes give no result.
//  The eighth header byte of a zero-length frame gives the empty marker.
//  rst_n is synchronous; it clears the header counter and the output valid.
//  in_ch.ready is low only while a result is held and out_ch.ready is low.

module length_type_deframer
  import ltd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ltd_in_if.sink      in_ch,
  ltd_out_if.source   out_ch
);

  logic [CNT_W-1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [WORD_W-1:0] len_r, len_nxt;
  logic [WORD_W-1:0] type_r, type_nxt;
  logic [WORD_W-1:0] rem_r, rem_nxt;
  logic              first_r, first_nxt;
  logic              out_valid_r, out_valid_nxt;
  ltd_result_t       out_r;

  ltd_result_t       res;
  logic              res_vld;
  logic              in_take;
  logic [CNT_W-1:0]  cnt_eff;
  logic [WORD_W-1:0] rem_dec;
  logic [4:0]        lane_ofs;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Out-of-range counter values fall back to the start of a header.
  assign cnt_eff  = (hdr_cnt_r > PAYLOAD_PHASE) ? '0 : hdr_cnt_r;
  assign lane_ofs = {cnt_eff[1:0], 3'b000};
  assign rem_dec  = (rem_r != '0) ? rem_r - 1'b1 : rem_r;

  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    len_nxt     = len_r;
    type_nxt    = type_r;
    rem_nxt     = rem_r;
    first_nxt   = first_r;
    res_vld     = 1'b0;
    res         = '0;
    if (in_take) begin
      if (cnt_eff == PAYLOAD_PHASE) begin
        res_vld            = 1'b1;
        res.payload_byte   = in_ch.in_byte;
        res.message_type   = type_r;
        res.message_length = len_r;
        res.first_byte     = first_r;
        res.last_byte      = (rem_r <= 32'd1);
        res.empty_message  = 1'b0;
        first_nxt          = 1'b0;
        rem_nxt            = rem_dec;
        if (rem_dec == '0) begin
          hdr_cnt_nxt = '0;
          first_nxt   = 1'b1;
        end
      end else begin
        if (!cnt_eff[2]) begin
          len_nxt[lane_ofs +: BYTE_W] = in_ch.in_byte;
        end else begin
          type_nxt[lane_ofs +: BYTE_W] = in_ch.in_byte;
        end
        hdr_cnt_nxt = cnt_eff + 1'b1;
        if (cnt_eff == HDR_LAST) begin
          first_nxt = 1'b1;
          if (len_nxt == '0) begin
            res_vld            = 1'b1;
            res.message_type   = type_nxt;
            res.message_length = '0;
            res.first_byte     = 1'b1;
            res.last_byte      = 1'b1;
            res.empty_message  = 1'b1;
            hdr_cnt_nxt        = '0;
            rem_nxt            = '0;
          end else begin
            rem_nxt     = len_nxt;
            hdr_cnt_nxt = PAYLOAD_PHASE;
          end
        end
      end
    end
  end

  // A held result stays until its transfer; a new result replaces it only
  // when the input side was allowed to move.
  assign out_valid_nxt = res_vld ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_cnt_r   <= '0;
      len_r       <= '0;
      type_r      <= '0;
      rem_r       <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      hdr_cnt_r   <= hdr_cnt_nxt;
      len_r       <= len_nxt;
      type_r      <= type_nxt;
      rem_r       <= rem_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.payload_byte   = out_r.payload_byte;
  assign out_ch.message_type   = out_r.message_type;
  assign out_ch.message_length = out_r.message_length;
  assign out_ch.first_byte     = out_r.first_byte;
  assign out_ch.last_byte      = out_r.last_byte;
  assign out_ch.empty_message  = out_r.empty_message;

endmodule

// ===== hdl/ltd_checker.sv =====
// Port-level checker for the deframer and the bind that attaches it.
// Depends on ltd_pkg and length_type_deframer_macros.svh.
`timescale 1ns / 1ps
`include "length_type_deframer_macros.svh"

module ltd_checker
  import ltd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] payload_byte,
  input logic [WORD_W-1:0] message_type,
  input logic [WORD_W-1:0] message_length,
  input logic              first_byte,
  input logic              last_byte,
  input logic              empty_message
);

  logic [BYTE_W+2*WORD_W+2:0] out_bus;

  assign out_bus = {payload_byte, message_type, message_length,
                    first_byte, last_byte, empty_message};

  // A stalled result keeps its valid and its contents.
  `LTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bus))

  // The empty marker is a lone result of length zero with no byte.
  `LTD_ASSERT_SAME(a_empty_shape, out_valid && empty_message, first_byte && last_byte && payload_byte == '0 && message_length == '0)

  // A result that is not the last one belongs to a message of two bytes or more.
  `LTD_ASSERT_SAME(a_not_last_len, out_valid && !last_byte, !empty_message && message_length > 32'd1)

  // A new result appears only after an input transfer.
  `LTD_ASSERT_SAME(a_result_cause, $rose(out_valid), $past(in_valid && in_ready))

endmodule

bind length_type_deframer ltd_checker u_ltd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .payload_byte   (out_ch.payload_byte),
  .message_type   (out_ch.message_type),
  .message_length (out_ch.message_length),
  .first_byte     (out_ch.first_byte),
  .last_byte      (out_ch.last_byte),
  .empty_message  (out_ch.empty_message)
);

// ===== test/tb_length_type_deframer.sv =====
// Self-checking testbench for length_type_deframer: drives framed byte streams,
// predicts the tagged payload results and compares them on the output channel.
// Depends on ltd_pkg and the channel interfaces in ltd_ifs.sv.
`timescale 1ns / 1ps

module tb_length_type_deframer;
  import ltd_pkg::*;

  localparam int unsigned RANDOM_BYTES = 650;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  ltd_in_if  in_ch();
  ltd_out_if out_ch();

  length_type_deframer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Deframer state as seen by the predictor.
  logic [CNT_W-1:0]  hdr_count     = '0;
  logic [WORD_W-1:0] len_word      = '0;
  logic [WORD_W-1:0] type_word     = '0;
  logic [WORD_W-1:0] bytes_left    = '0;
  logic              first_pending = 1'b1;

  ltd_result_t expected_results[$];
  int          mismatches    = 0;
  int unsigned bytes_sent    = 0;
  bit          in_idle_on    = 1'b1;
  bit          out_idle_on   = 1'b1;
  bit          long_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Appends one predicted result at the tail of the expected queue.
  function automatic void queue_expected(input ltd_result_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Advances the predicted deframer by one stream byte and queues any result.
  function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
    ltd_result_t r;
    if (hdr_count == PAYLOAD_PHASE) begin
      r.payload_byte   = b;
      r.message_type   = type_word;
      r.message_length = len_word;
      r.first_byte     = first_pending;
      r.last_byte      = (bytes_left <= 1);
      r.empty_message  = 1'b0;
      queue_expected(r);
      first_pending = 1'b0;
      if (bytes_left != 0) bytes_left = bytes_left - 1;
      if (bytes_left == 0) begin
        hdr_count     = '0;
        first_pending = 1'b1;
      end
      return;
    end
    if (hdr_count < 4) begin
      len_word[int'(hdr_count) * 8 +: 8] = b;
    end else begin
      type_word[(int'(hdr_count) - 4) * 8 +: 8] = b;
    end
    if (hdr_count == HDR_LAST) begin
      first_pending = 1'b1;
      if (len_word == 0) begin
        r.payload_byte   = '0;
        r.message_type   = type_word;
        r.message_length = '0;
        r.first_byte     = 1'b1;
        r.last_byte      = 1'b1;
        r.empty_message  = 1'b1;
        queue_expected(r);
        hdr_count  = '0;
        bytes_left = '0;
      end else begin
        bytes_left = len_word;
        hdr_count  = PAYLOAD_PHASE;
      end
    end else begin
      hdr_count = hdr_count + 1'b1;
    end
  endfunction

  // Offers one byte and returns at the edge where the transfer happens.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [WORD_W-1:0] len, input logic [WORD_W-1:0] typ);
    for (int i = 0; i < 4; i++) send_byte(len[i*8 +: 8]);
    for (int i = 0; i < 4; i++) send_byte(typ[i*8 +: 8]);
  endtask

  task automatic send_frame(input int unsigned len, input logic [WORD_W-1:0] typ);
    send_header(len, typ);
    for (int unsigned i = 0; i < len; i++) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Empty message, then the shortest payloads with extreme byte values.
  task automatic test_directed_frames();
    send_header('0, '1);
    send_header(32'd1, '0);
    send_byte(8'hFF);
    send_header(32'd2, 32'h8000_0001);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // The sink stalls long enough for the output register to fill and block the input.
  task automatic test_output_stall();
    in_idle_on    = 1'b0;
    long_hold_req = 1'b1;
    send_frame(256, $urandom);
    in_idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int unsigned stop_at;
    int unsigned roll;
    int unsigned len;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) len = 0;
      else if (roll < 85) len = $urandom_range(1, 16);
      else len = $urandom_range(17, 64);
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      send_frame(len, $urandom);
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // A frame of the largest length is streamed for a while and left unfinished,
  // so this test has to come last.
  task automatic test_long_message();
    send_header('1, $urandom);
    for (int i = 0; i < 48; i++) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  initial begin : result_sink
    int wait_left;
    out_ch.ready <= 1'b0;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        wait_left     = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (wait_left > 0) begin
        wait_left--;
        out_ch.ready <= (wait_left == 0);
      end else begin
        wait_left = out_idle_on ? pick_gap() : 0;
        out_ch.ready <= (wait_left == 0);
      end
    end
  end

  function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    ltd_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with no result pending: payload_byte 0x%0h",
               out_ch.payload_byte);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("payload_byte", WORD_W'(exp_r.payload_byte),
                    WORD_W'(out_ch.payload_byte));
        check_field("message_type", exp_r.message_type, out_ch.message_type);
        check_field("message_length", exp_r.message_length, out_ch.message_length);
        check_field("first_byte", WORD_W'(exp_r.first_byte), WORD_W'(out_ch.first_byte));
        check_field("last_byte", WORD_W'(exp_r.last_byte), WORD_W'(out_ch.last_byte));
        check_field("empty_message", WORD_W'(exp_r.empty_message),
                    WORD_W'(out_ch.empty_message));
      end
    end
  end

  initial begin : stimulus
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_output_stall();
    test_random_frames();
    test_long_message();

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
